// File: hw/rtl/pidpd_pkg.sv
// shared types and constants of the pid position/delta controller
`default_nettype none

package pidpd_pkg;

  // word format, signed fixed point
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIM_W     = 31;
  localparam int WIDE_W    = DATA_W + 4;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int Q_W       = PROD_W - FRAC_BITS;
  localparam int IDX_W     = 3;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic        [LIM_W-1:0]  lim_t;

  // saturation bounds of one word
  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam wide_t WIDE_MAX = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam wide_t WIDE_MIN = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // loop mode codes
  localparam logic MODE_POSITION = 1'b0;
  localparam logic MODE_DELTA    = 1'b1;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_LOOP_MODE      = 3'd0,
    CFG_GAIN_P         = 3'd1,
    CFG_GAIN_I         = 3'd2,
    CFG_GAIN_D         = 3'd3,
    CFG_OUTPUT_LIMIT   = 3'd4,
    CFG_INTEGRAL_LIMIT = 3'd5,
    CFG_DEAD_BAND      = 3'd6
  } cfg_idx_t;

  // reset value of both limits: full positive range
  localparam lim_t LIM_RESET = {LIM_W{1'b1}};

endpackage

`default_nettype wire

// File: hw/rtl/pid_position_delta_controller_core.sv
// pid controller core, positional or incremental, signed fixed point
// throughput: one item per cycle while out_stall is low, through four register stages
// (input, error, products, result) that each advance when the next has room
// reset (rst_n low, synchronous): all stages empty, configuration registers to their reset
// values, error history, integral and last drive cleared to zero
`default_nettype none

module pid_position_delta_controller_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic signed [pidpd_pkg::DATA_W-1:0] in_feedback,
  input  wire logic signed [pidpd_pkg::DATA_W-1:0] in_setpoint,
  input  wire logic        [pidpd_pkg::LIM_W-1:0]  in_wrap_range,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [pidpd_pkg::DATA_W-1:0] out_drive,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [pidpd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pidpd_pkg::DATA_W-1:0]  cfg_data
);

  // saturate a wide value to one word
  function automatic pidpd_pkg::word_t sat_word(input pidpd_pkg::wide_t x);
    pidpd_pkg::word_t r;
    if (x > pidpd_pkg::WIDE_MAX) begin
      r = pidpd_pkg::WORD_MAX;
    end else if (x < pidpd_pkg::WIDE_MIN) begin
      r = pidpd_pkg::WORD_MIN;
    end else begin
      r = x[pidpd_pkg::DATA_W-1:0];
    end
    return r;
  endfunction

  // symmetric clamp to plus or minus lim
  function automatic pidpd_pkg::wide_t clamp_sym(input pidpd_pkg::wide_t x,
                                                 input pidpd_pkg::lim_t lim);
    pidpd_pkg::wide_t lw;
    pidpd_pkg::wide_t r;
    lw = pidpd_pkg::wide_t'(lim);
    if (x > lw) begin
      r = lw;
    end else if (x < -lw) begin
      r = -lw;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // fixed point product, floor shift, saturated to one word
  function automatic pidpd_pkg::word_t qmul(input pidpd_pkg::word_t a,
                                            input pidpd_pkg::word_t b);
    logic signed [pidpd_pkg::PROD_W-1:0]            prod;
    logic        [pidpd_pkg::Q_W-pidpd_pkg::DATA_W:0] hi;
    pidpd_pkg::word_t                                r;
    prod = a * b;
    hi   = prod[pidpd_pkg::PROD_W-1:pidpd_pkg::FRAC_BITS+pidpd_pkg::DATA_W-1];
    if ((&hi) || !(|hi)) begin
      r = prod[pidpd_pkg::FRAC_BITS+pidpd_pkg::DATA_W-1:pidpd_pkg::FRAC_BITS];
    end else if (hi[pidpd_pkg::Q_W-pidpd_pkg::DATA_W]) begin
      r = pidpd_pkg::WORD_MIN;
    end else begin
      r = pidpd_pkg::WORD_MAX;
    end
    return r;
  endfunction

  // configuration registers
  logic              loop_mode_r;
  pidpd_pkg::word_t  gain_p_r, gain_i_r, gain_d_r;
  pidpd_pkg::lim_t   out_lim_r, int_lim_r, dead_band_r;

  // controller state
  pidpd_pkg::word_t  prev_err_r, prev_err_nxt;
  pidpd_pkg::word_t  pprev_err_r, pprev_err_nxt;
  pidpd_pkg::word_t  integral_r, integral_nxt;
  pidpd_pkg::word_t  last_drive_r, last_drive_nxt;

  // stage valids
  logic s0_valid_r, s0_valid_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  // stage payloads
  pidpd_pkg::word_t s0_fb_r, s0_sp_r;
  pidpd_pkg::lim_t  s0_range_r;
  pidpd_pkg::word_t s1_err_r, s1_err_nxt;
  pidpd_pkg::word_t s2_err_r;
  pidpd_pkg::word_t s2_qp_r, s2_qi_r, s2_qd_r;
  pidpd_pkg::word_t s2_qp_nxt, s2_qi_nxt, s2_qd_nxt;
  pidpd_pkg::word_t out_drive_r, drive_nxt;

  // stage handshakes
  logic out_free, s2_free, s1_free, s0_free;
  logic in_go, s1_load, s2_load, s3_load;

  assign out_free = !out_valid_r || !out_stall;
  assign s3_load  = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s2_load  = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign s1_load  = s0_valid_r && s1_free;
  assign s0_free  = !s0_valid_r || s1_free;
  assign in_go    = in_valid && s0_free;

  assign in_stall  = !s0_free;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign cfg_ready = 1'b1;

  assign s0_valid_nxt  = in_go   || (s0_valid_r && !s1_load);
  assign s1_valid_nxt  = s1_load || (s1_valid_r && !s2_load);
  assign s2_valid_nxt  = s2_load || (s2_valid_r && !s3_load);
  assign out_valid_nxt = s3_load || (out_valid_r && out_stall);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r <= pidpd_pkg::MODE_POSITION;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      out_lim_r   <= pidpd_pkg::LIM_RESET;
      int_lim_r   <= pidpd_pkg::LIM_RESET;
      dead_band_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidpd_pkg::CFG_LOOP_MODE:      loop_mode_r <= cfg_data[0];
        pidpd_pkg::CFG_GAIN_P:         gain_p_r    <= cfg_data;
        pidpd_pkg::CFG_GAIN_I:         gain_i_r    <= cfg_data;
        pidpd_pkg::CFG_GAIN_D:         gain_d_r    <= cfg_data;
        pidpd_pkg::CFG_OUTPUT_LIMIT:   out_lim_r   <= cfg_data[pidpd_pkg::LIM_W-1:0];
        pidpd_pkg::CFG_INTEGRAL_LIMIT: int_lim_r   <= cfg_data[pidpd_pkg::LIM_W-1:0];
        pidpd_pkg::CFG_DEAD_BAND:      dead_band_r <= cfg_data[pidpd_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // error stage: difference, one fold toward the shortest path, saturate
  always_comb begin
    pidpd_pkg::wide_t diff;
    pidpd_pkg::wide_t rng;
    pidpd_pkg::wide_t twice;
    diff  = pidpd_pkg::wide_t'(s0_sp_r) - pidpd_pkg::wide_t'(s0_fb_r);
    rng   = pidpd_pkg::wide_t'(s0_range_r);
    twice = diff <<< 1;
    if (rng != '0) begin
      if (twice > rng) begin
        diff = diff - rng;
      end else if (twice < -rng) begin
        diff = diff + rng;
      end
    end
    s1_err_nxt = sat_word(diff);
  end

  // product stage: error differences and the three gain products
  always_comb begin
    pidpd_pkg::word_t d1;
    pidpd_pkg::word_t d2;
    d1 = sat_word(pidpd_pkg::wide_t'(s1_err_r) - pidpd_pkg::wide_t'(prev_err_r));
    d2 = sat_word(pidpd_pkg::wide_t'(s1_err_r) - (pidpd_pkg::wide_t'(prev_err_r) <<< 1)
                  + pidpd_pkg::wide_t'(pprev_err_r));
    s2_qi_nxt = qmul(gain_i_r, s1_err_r);
    if (loop_mode_r == pidpd_pkg::MODE_DELTA) begin
      s2_qp_nxt = qmul(gain_p_r, d1);
      s2_qd_nxt = qmul(gain_d_r, d2);
    end else begin
      s2_qp_nxt = qmul(gain_p_r, s1_err_r);
      s2_qd_nxt = qmul(gain_d_r, d1);
    end
    prev_err_nxt  = s2_load ? s1_err_r   : prev_err_r;
    pprev_err_nxt = s2_load ? prev_err_r : pprev_err_r;
  end

  // result stage: integral, sum, dead band and output clamp
  always_comb begin
    pidpd_pkg::wide_t isum;
    pidpd_pkg::wide_t total;
    pidpd_pkg::wide_t mag;
    pidpd_pkg::wide_t raw;
    pidpd_pkg::wide_t clamped;
    if (loop_mode_r == pidpd_pkg::MODE_DELTA) begin
      isum  = pidpd_pkg::wide_t'(s2_qi_r);
      total = pidpd_pkg::wide_t'(last_drive_r) + pidpd_pkg::wide_t'(s2_qp_r)
            + isum + pidpd_pkg::wide_t'(s2_qd_r);
    end else begin
      isum  = pidpd_pkg::wide_t'(sat_word(pidpd_pkg::wide_t'(integral_r)
                                          + pidpd_pkg::wide_t'(s2_qi_r)));
      isum  = clamp_sym(isum, int_lim_r);
      total = pidpd_pkg::wide_t'(s2_qp_r) + isum + pidpd_pkg::wide_t'(s2_qd_r);
    end
    raw = pidpd_pkg::wide_t'(sat_word(total));
    mag = pidpd_pkg::wide_t'(s2_err_r);
    if (mag < 0) begin
      mag = -mag;
    end
    if (mag <= pidpd_pkg::wide_t'(dead_band_r)) begin
      raw = '0;
    end
    clamped        = clamp_sym(raw, out_lim_r);
    drive_nxt      = clamped[pidpd_pkg::DATA_W-1:0];
    integral_nxt   = s3_load ? isum[pidpd_pkg::DATA_W-1:0] : integral_r;
    last_drive_nxt = s3_load ? drive_nxt : last_drive_r;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_err_r   <= '0;
      pprev_err_r  <= '0;
      integral_r   <= '0;
      last_drive_r <= '0;
    end else begin
      s0_valid_r   <= s0_valid_nxt;
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_err_r   <= prev_err_nxt;
      pprev_err_r  <= pprev_err_nxt;
      integral_r   <= integral_nxt;
      last_drive_r <= last_drive_nxt;
    end
  end

  // payload registers, loaded on each stage transfer
  always_ff @(posedge clk) begin
    if (in_go) begin
      s0_fb_r    <= in_feedback;
      s0_sp_r    <= in_setpoint;
      s0_range_r <= in_wrap_range;
    end
    if (s1_load) begin
      s1_err_r <= s1_err_nxt;
    end
    if (s2_load) begin
      s2_err_r <= s1_err_r;
      s2_qp_r  <= s2_qp_nxt;
      s2_qi_r  <= s2_qi_nxt;
      s2_qd_r  <= s2_qd_nxt;
    end
    if (s3_load) begin
      out_drive_r <= drive_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a shown result never exceeds the output limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pidpd_pkg::wide_t'(out_drive_r) <= pidpd_pkg::wide_t'(out_lim_r)) &&
                    (pidpd_pkg::wide_t'(out_drive_r) >= -pidpd_pkg::wide_t'(out_lim_r)))
    else $error("drive outside output limit");

  // positional steps keep the integral inside its limit
  assert property (@(posedge clk) disable iff (!rst_n)
    (s3_load && (loop_mode_r == pidpd_pkg::MODE_POSITION)) |=>
      (pidpd_pkg::wide_t'(integral_r) <= pidpd_pkg::wide_t'(int_lim_r)) &&
      (pidpd_pkg::wide_t'(integral_r) >= -pidpd_pkg::wide_t'(int_lim_r)))
    else $error("integral outside integral limit");

  // error inside the dead band gives a zero drive
  assert property (@(posedge clk) disable iff (!rst_n)
    (s3_load && (s2_err_r >= -pidpd_pkg::word_t'(dead_band_r)) &&
     (s2_err_r <= pidpd_pkg::word_t'(dead_band_r))) |=> (out_drive_r == '0))
    else $error("drive not zero inside dead band");

  // a held product stage keeps its item until the result register has room
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_free) |=> s2_valid_r && $stable(s2_qp_r) && $stable(s2_err_r))
    else $error("product stage lost a held item");

  // the last drive always tracks the result register after a transfer in
  assert property (@(posedge clk) disable iff (!rst_n)
    s3_load |=> (last_drive_r == out_drive_r) && out_valid_r)
    else $error("last drive out of step with result");
`endif

endmodule

`default_nettype wire
